[rtl/button_debounce_autorepeat_macros.svh]
// Assertion helpers shared by the debounce block.
`ifndef BUTTON_DEBOUNCE_AUTOREPEAT_MACROS_SVH
`define BUTTON_DEBOUNCE_AUTOREPEAT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BDA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BDA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/bda_pkg.sv]
package bda_pkg;

  localparam int PinW    = 5;
  localparam int BtnIdxW = 3;
  localparam int CfgW    = 8;

  // reset values of the configuration registers, and the debounce limit maximum
  localparam logic [CfgW-1:0] DebounceReset    = 8'd10;
  localparam logic [CfgW-1:0] RepeatFirstReset = 8'd100;
  localparam logic [CfgW-1:0] RepeatIntReset   = 8'd30;
  localparam logic [CfgW-1:0] DebounceMax      = 8'd254;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_TAKE  = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_FIRST    = 2'd1,
    CFG_INTERVAL = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [CfgW-1:0] limit;
    logic [CfgW-1:0] first;
    logic [CfgW-1:0] interval;
  } bda_cfg_t;

  typedef struct packed {
    logic  en;
    func_e func;
  } bda_ctrl_t;

endpackage

[rtl/bda_if.sv]
// Input item channel
interface bda_in_if import bda_pkg::*; ();
  logic                 valid;
  logic                 ready;
  func_e                func;
  logic [PinW-1:0]      pin_levels;
  logic [BtnIdxW-1:0]   button_index;

  modport source (output valid, func, pin_levels, button_index, input ready);
  modport sink   (input valid, func, pin_levels, button_index, output ready);
endinterface

// Result item channel
interface bda_out_if import bda_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            press_taken;
  logic [PinW-1:0] held_mask;
  logic [PinW-1:0] pending_mask;

  modport source (output valid, press_taken, held_mask, pending_mask, input ready);
  modport sink   (input valid, press_taken, held_mask, pending_mask, output ready);
endinterface

// Configuration write channel
interface bda_cfg_if import bda_pkg::*; ();
  logic            valid;
  logic            ready;
  cfg_idx_e        index;
  logic [CfgW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/bda_cell.sv]
// Per-button debounce, repeat counter and press flag.
module bda_cell import bda_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  bda_cfg_t  cfg_i,
  input  bda_ctrl_t ctrl_i,
  input  logic      level_i,
  input  logic      sel_i,
  output logic      held_o,
  output logic      pending_o,
  output logic      taken_o
);

  logic            stable_q, stable_d;
  logic [CfgW-1:0] change_q, change_d;
  logic [CfgW-1:0] repeat_q, repeat_d;
  logic            flag_q, flag_d;
  logic [CfgW-1:0] repeat_dec;

  // saturating count-down of the repeat counter
  assign repeat_dec = (repeat_q == '0) ? '0 : repeat_q - 8'd1;

  // next state for one item
  always_comb begin
    stable_d = stable_q;
    change_d = change_q;
    repeat_d = repeat_q;
    flag_d   = flag_q;
    taken_o  = 1'b0;
    if (ctrl_i.en) begin
      unique case (ctrl_i.func)
        FUNC_TICK: begin
          if (level_i == stable_q) begin
            change_d = '0;
            if (!level_i) begin
              if (repeat_dec == '0) begin
                repeat_d = cfg_i.interval;
                flag_d   = 1'b1;
              end else begin
                repeat_d = repeat_dec;
              end
            end
          end else if (change_q > cfg_i.limit) begin
            change_d = '0;
            repeat_d = cfg_i.first;
            stable_d = level_i;
            if (!level_i) flag_d = 1'b1;
          end else begin
            change_d = change_q + 8'd1;
          end
        end
        FUNC_TAKE: begin
          if (sel_i) begin
            taken_o = flag_q;
            flag_d  = 1'b0;
          end
        end
        FUNC_CLEAR: flag_d = 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= 1'b1;
      change_q <= '0;
      repeat_q <= RepeatFirstReset;
      flag_q   <= 1'b0;
    end else begin
      stable_q <= stable_d;
      change_q <= change_d;
      repeat_q <= repeat_d;
      flag_q   <= flag_d;
    end
  end

  // state after this item, for the result
  assign held_o    = ~stable_d;
  assign pending_o = flag_d;

endmodule

[rtl/button_debounce_autorepeat.sv]
// Debouncer with auto-repeat for active-low buttons.
// Channels: in_i carries items (func: sample tick, take one flag, clear all
// flags; pin_levels; button_index), out_o returns one result per item
// (press_taken, held_mask, pending_mask), cfg_i writes the debounce limit,
// first repeat delay and repeat interval (index 0..2, always ready; write
// only while no item is in flight).
// Pipeline: the input transfer loads the input register and the per-button
// update then loads the result register, from which out_o presents the
// result; one item per cycle sustained while out_o is taken, the per-button
// update between those registers being combinational.
// Stall: when out_o is not taken, the result holds and one more item may
// wait in the input register; in_i.ready then drops until out_o moves.
// Reset: all buttons released, counters and flags cleared, repeat counters
// loaded with the reset first delay, registers at 10 / 100 / 30; both
// pipeline registers empty. No clearing pass: items are accepted at once.
`include "button_debounce_autorepeat_macros.svh"

module button_debounce_autorepeat import bda_pkg::*; #(
  parameter int NUM_BUTTONS = 5
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  bda_cfg_if.sink   cfg_i,
  bda_in_if.sink    in_i,
  bda_out_if.source out_o
);

  // configuration registers
  bda_cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_DEBOUNCE: cfg_d.limit    = (cfg_i.data > DebounceMax) ? DebounceMax : cfg_i.data;
        CFG_FIRST:    cfg_d.first    = (cfg_i.data == '0) ? 8'd1 : cfg_i.data;
        CFG_INTERVAL: cfg_d.interval = (cfg_i.data == '0) ? 8'd1 : cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.limit    <= DebounceReset;
      cfg_q.first    <= RepeatFirstReset;
      cfg_q.interval <= RepeatIntReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // input register stage
  logic               s1_valid_q;
  func_e              s1_func_q;
  logic [PinW-1:0]    s1_pins_q;
  logic [BtnIdxW-1:0] s1_idx_q;
  logic               out_valid_q;
  logic               s1_move;
  logic               in_xfer;

  assign s1_move    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_move;
  assign in_xfer    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_func_q <= in_i.func;
      s1_pins_q <= in_i.pin_levels;
      s1_idx_q  <= in_i.button_index;
    end
  end

  // per-button cells
  bda_ctrl_t              ctrl;
  logic [NUM_BUTTONS-1:0] held_next;
  logic [NUM_BUTTONS-1:0] pend_next;
  logic [NUM_BUTTONS-1:0] taken_vec;
  logic [PinW-1:0]        held_vis;
  logic [PinW-1:0]        pend_vis;

  assign ctrl.en   = s1_move;
  assign ctrl.func = s1_func_q;

  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_cell
    logic lvl;
    logic sel;
    if (i < PinW) begin : g_pin
      assign lvl = s1_pins_q[i];
    end else begin : g_nopin
      assign lvl = 1'b0;
    end
    if (i < (1 << BtnIdxW)) begin : g_sel
      assign sel = (s1_idx_q == BtnIdxW'(i));
    end else begin : g_nosel
      assign sel = 1'b0;
    end
    bda_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cfg_i     (cfg_q),
      .ctrl_i    (ctrl),
      .level_i   (lvl),
      .sel_i     (sel),
      .held_o    (held_next[i]),
      .pending_o (pend_next[i]),
      .taken_o   (taken_vec[i])
    );
  end

  // only the first buttons appear in the masks
  for (genvar i = 0; i < PinW; i++) begin : g_mask
    if (i < NUM_BUTTONS) begin : g_on
      assign held_vis[i] = held_next[i];
      assign pend_vis[i] = pend_next[i];
    end else begin : g_off
      assign held_vis[i] = 1'b0;
      assign pend_vis[i] = 1'b0;
    end
  end

  // result register
  logic            taken_q;
  logic [PinW-1:0] held_q;
  logic [PinW-1:0] pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_o.ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      taken_q <= |taken_vec;
      held_q  <= held_vis;
      pend_q  <= pend_vis;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.press_taken  = taken_q;
  assign out_o.held_mask    = held_q;
  assign out_o.pending_mask = pend_q;

  // checks
  `BDA_ASSERT_NEXT(a_clear_empties, clk_i, rst_ni, s1_move && s1_func_q == FUNC_CLEAR, out_o.pending_mask == '0, "pending flags left after clear")
  `BDA_ASSERT_IMPL(a_full_blocks, clk_i, rst_ni, s1_valid_q && out_valid_q && !out_o.ready, !in_i.ready, "input taken while pipeline full")
  `BDA_ASSERT_IMPL(a_cfg_range, clk_i, rst_ni, 1'b1, cfg_q.limit != 8'hFF && cfg_q.first != '0 && cfg_q.interval != '0, "configuration register out of range")
  `BDA_ASSERT_NEXT(a_take_only, clk_i, rst_ni, s1_move && s1_func_q != FUNC_TAKE, !out_o.press_taken, "press reported without take")

endmodule
